### rtl/sfg_pkg.sv
`timescale 1ns / 1ps
// sfg_pkg: shared types, constants and the logistic sample table
// for the soft floor / gradient core; no dependencies
package sfg_pkg;

  localparam int MAX_REGIONS = 8;
  localparam int MAX_TERMS   = MAX_REGIONS - 1;
  localparam int TBL_ENTRIES = 256;
  localparam int TBL_LOG2    = $clog2(TBL_ENTRIES);
  localparam int AXIS_LAT    = 9;

  localparam logic [18:0] SOFT_MAX = 19'd458752;
  localparam logic [23:0] GRAD_MAX = 24'hFF_FFFF;
  localparam logic [16:0] ONE_Q16  = 17'd65536;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_INV_W    = 3'd2,
    CFG_INV_H    = 3'd3,
    CFG_REGIONS_X = 3'd4,
    CFG_REGIONS_Y = 3'd5,
    CFG_STEEPNESS = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               last_pin;
  } sfg_in_t;

  typedef struct packed {
    logic [18:0] soft_x;
    logic [18:0] soft_y;
    logic [23:0] grad_x;
    logic [23:0] grad_y;
    logic        last_out;
  } sfg_out_t;

  typedef logic [16:0] rom_t [0:TBL_ENTRIES];

  // restoring long division, only used while the table is built
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // logistic samples over [-8, 8], taylor exp then reciprocal, built at elaboration
  function automatic rom_t build_rom();
    rom_t r;
    longint num;
    longint sum;
    longint unsigned mag, u, v, term, e, den, lpos, jj;
    for (int k = 0; k <= TBL_ENTRIES; k++) begin
      num  = longint'(16 * k) - longint'(8 * TBL_ENTRIES);
      mag  = (num < 0) ? longint'(-num) : longint'(num);
      u    = (mag << 30) / TBL_ENTRIES;
      v    = u >> 4;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int j = 1; j < 16; j++) begin
        jj   = longint'(j);
        term = udiv((term * v) >> 30, jj);
        if (j % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      e = (sum < 0) ? 64'd0 : longint'(sum);
      for (int sq = 0; sq < 4; sq++) begin
        e = (e * e) >> 30;
      end
      den  = (64'd1 << 30) + e;
      lpos = udiv((64'd1 << 46) + (den >> 1), den);
      r[k] = (num < 0) ? 17'(64'd65536 - lpos) : 17'(lpos);
    end
    return r;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

endpackage

### rtl/sfg_axis.sv
`timescale 1ns / 1ps
// sfg_axis: nine-stage pipeline for one axis, scale, logistic terms, sums
// depends on sfg_pkg
module sfg_axis (
  input  logic               clk_i,
  input  logic signed [31:0] pos_i,
  input  logic signed [31:0] origin_i,
  input  logic        [15:0] inv_i,
  input  logic        [3:0]  regions_i,
  input  logic        [15:0] steep_i,
  output logic        [18:0] soft_o,
  output logic        [23:0] grad_o
);
  import sfg_pkg::*;

  logic signed [32:0] diff_q;
  logic signed [49:0] sprod_d;
  logic signed [32:0] s_q;
  logic signed [41:0] z_q     [MAX_TERMS];
  logic        [16:0] lo_q    [MAX_TERMS];
  logic signed [17:0] df_q    [MAX_TERMS];
  logic        [19:0] f_q     [MAX_TERMS];
  logic        [16:0] l_q     [MAX_TERMS];
  logic        [15:0] lt_q    [MAX_TERMS];
  logic        [31:0] term_q  [MAX_TERMS];
  logic        [19:0] ssum_d, ssum1_q, ssum2_q, ssum3_q;
  logic        [34:0] gsum_d, gsum_q;
  logic        [50:0] gprod_d;
  logic        [18:0] soft_q;
  logic        [23:0] grad_q;

  // stage 1: offset, stage 2: scale into region units
  assign sprod_d = diff_q * $signed({1'b0, inv_i});

  always_ff @(posedge clk_i) begin
    diff_q <= $signed({pos_i[31], pos_i}) - $signed({origin_i[31], origin_i});
    s_q    <= sprod_d[48:16];
  end

  for (genvar t = 0; t < MAX_TERMS; t++) begin : g_term
    logic signed [33:0] d_d;
    logic signed [50:0] zp_d;
    logic               neg_d, pos_d;
    logic        [19:0] p_d;
    logic [TBL_LOG2-1:0] k_d;
    logic        [16:0] rlo_d, rhi_d;
    logic signed [38:0] ip_d;
    logic signed [38:0] lsum_d;
    logic        [16:0] lc_d;
    logic        [33:0] lp_d;
    logic               use_d;

    assign d_d  = $signed({s_q[32], s_q}) - $signed(34'(t + 1) << 16);
    assign zp_d = d_d * $signed({1'b0, steep_i});

    assign neg_d = z_q[t] < -42'sd524288;
    assign pos_d = z_q[t] >= 42'sd524288;
    assign p_d   = {~z_q[t][19], z_q[t][18:0]};
    assign k_d   = p_d[19 -: TBL_LOG2];
    assign rlo_d = SIG_ROM[(TBL_LOG2+1)'(k_d)];
    assign rhi_d = SIG_ROM[(TBL_LOG2+1)'(k_d) + (TBL_LOG2+1)'(1)];

    assign ip_d   = df_q[t] * $signed({1'b0, f_q[t]});
    assign lsum_d = $signed({22'd0, lo_q[t]}) + (ip_d >>> 20);

    assign lc_d = ONE_Q16 - l_q[t];
    assign lp_d = l_q[t] * lc_d;
    assign use_d = int'(regions_i) > t + 1;

    always_ff @(posedge clk_i) begin
      z_q[t] <= zp_d[49:8];
      // out-of-range arguments saturate through a flat segment
      if (neg_d) begin
        lo_q[t] <= '0;
        df_q[t] <= '0;
      end else if (pos_d) begin
        lo_q[t] <= ONE_Q16;
        df_q[t] <= '0;
      end else begin
        lo_q[t] <= rlo_d;
        df_q[t] <= $signed({1'b0, rhi_d}) - $signed({1'b0, rlo_d});
      end
      f_q[t]    <= {p_d[19-TBL_LOG2:0], {TBL_LOG2{1'b0}}};
      l_q[t]    <= use_d ? lsum_d[16:0] : '0;
      lt_q[t]   <= lp_d[31:16];
      term_q[t] <= steep_i * lt_q[t];
    end
  end

  always_comb begin
    ssum_d = '0;
    gsum_d = '0;
    for (int t = 0; t < MAX_TERMS; t++) begin
      ssum_d = ssum_d + 20'(l_q[t]);
      gsum_d = gsum_d + 35'(term_q[t]);
    end
  end

  assign gprod_d = gsum_q * inv_i;

  always_ff @(posedge clk_i) begin
    ssum1_q <= ssum_d;
    ssum2_q <= ssum1_q;
    ssum3_q <= ssum2_q;
    gsum_q  <= gsum_d;
    soft_q  <= (ssum3_q > 20'(SOFT_MAX)) ? SOFT_MAX : ssum3_q[18:0];
    grad_q  <= (gprod_d[50:24] > 27'(GRAD_MAX)) ? GRAD_MAX : gprod_d[47:24];
  end

  assign soft_o = soft_q;
  assign grad_o = grad_q;

endmodule

### rtl/soft_floor_with_gradient_core.sv
`timescale 1ns / 1ps
// throughput: one transaction per cycle, busy_o never rises
// the rate is set by the nine-stage axis pipelines, one per axis
// reset: asynchronous active low, clears valid bits and loads register defaults
// results are not stalled: each is shown for one cycle under done_o
module soft_floor_with_gradient_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  sfg_pkg::sfg_in_t  in_i,
  output logic              done_o,
  output sfg_pkg::sfg_out_t result_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i
);
  import sfg_pkg::*;

  // configuration registers
  logic signed [31:0] origin_x_q, origin_y_q;
  logic        [15:0] inv_w_q, inv_h_q, steep_q;
  logic        [3:0]  regions_x_q, regions_y_q;

  // valid and last flags travel alongside the axis data
  logic [AXIS_LAT-1:0] valid_q;
  logic [AXIS_LAT-1:0] last_q;
  logic                accept;

  logic [18:0] soft_x, soft_y;
  logic [23:0] grad_x, grad_y;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      inv_w_q     <= 16'd4096;
      inv_h_q     <= 16'd4096;
      regions_x_q <= 4'd1;
      regions_y_q <= 4'd1;
      steep_q     <= 16'd2560;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X:  origin_x_q  <= cfg_wdata_i;
        CFG_ORIGIN_Y:  origin_y_q  <= cfg_wdata_i;
        CFG_INV_W:     inv_w_q     <= cfg_wdata_i[15:0];
        CFG_INV_H:     inv_h_q     <= cfg_wdata_i[15:0];
        CFG_REGIONS_X: regions_x_q <= cfg_wdata_i[3:0];
        CFG_REGIONS_Y: regions_y_q <= cfg_wdata_i[3:0];
        CFG_STEEPNESS: steep_q     <= cfg_wdata_i[15:0];
        default: ; // index past the register list is dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[AXIS_LAT-2:0], accept};
    end
  end

  // last flag is payload, no reset needed
  always_ff @(posedge clk_i) begin
    last_q <= {last_q[AXIS_LAT-2:0], in_i.last_pin};
  end

  sfg_axis u_axis_x (
    .clk_i     (clk_i),
    .pos_i     (in_i.pos_x),
    .origin_i  (origin_x_q),
    .inv_i     (inv_w_q),
    .regions_i (regions_x_q),
    .steep_i   (steep_q),
    .soft_o    (soft_x),
    .grad_o    (grad_x)
  );

  sfg_axis u_axis_y (
    .clk_i     (clk_i),
    .pos_i     (in_i.pos_y),
    .origin_i  (origin_y_q),
    .inv_i     (inv_h_q),
    .regions_i (regions_y_q),
    .steep_i   (steep_q),
    .soft_o    (soft_y),
    .grad_o    (grad_y)
  );

  // result transaction straight from the final pipeline registers
  assign done_o            = valid_q[AXIS_LAT-1];
  assign result_o.soft_x   = soft_x;
  assign result_o.soft_y   = soft_y;
  assign result_o.grad_x   = grad_x;
  assign result_o.grad_y   = grad_y;
  assign result_o.last_out = last_q[AXIS_LAT-1];

`ifndef SYNTHESIS
  // every result traces back to an accepted start that entered the pipeline earlier
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, AXIS_LAT))
    else $error("done without matching start");

  // soft floor sums never pass the top of their range
  a_soft_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.soft_x <= SOFT_MAX) && (result_o.soft_y <= SOFT_MAX))
    else $error("soft floor out of range");
`endif

endmodule

### sim/sfg_checker.sv
`timescale 1ns / 1ps
// sfg_checker: watches the pin, config and result channels of the soft floor core,
// predicts every result and compares it; depends on sfg_pkg
module sfg_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  sfg_pkg::sfg_in_t  in_i,
  input  logic              done_i,
  input  sfg_pkg::sfg_out_t result_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,
  output int                pending_o,
  output int                errors_o
);

  localparam int           NSAMP = 256;
  localparam longint       HALF  = 524288;

  longint unsigned  sig_tab [0:NSAMP];
  sfg_pkg::sfg_out_t expected_q [$];
  int               errors;

  longint           org_x, org_y;
  longint unsigned  inv_w, inv_h, steep;
  int               nreg_x, nreg_y;

  assign pending_o = expected_q.size();
  assign errors_o  = errors;

  initial begin
    longint          num;
    longint          acc;
    longint unsigned u, v, t, e, den, lp;
    for (int k = 0; k <= NSAMP; k++) begin
      num = 16 * k - 8 * NSAMP;
      u   = (longint'(num < 0 ? -num : num) << 30) / NSAMP;
      v   = u >> 4;
      t   = 64'd1 << 30;
      acc = longint'(t);
      for (int j = 1; j < 16; j++) begin
        t   = ((t * v) >> 30) / j;
        acc = (j % 2) ? acc - longint'(t) : acc + longint'(t);
      end
      e = (acc < 0) ? 0 : acc;
      repeat (4) e = (e * e) >> 30;
      den = (64'd1 << 30) + e;
      lp  = ((64'd1 << 46) + den / 2) / den;
      sig_tab[k] = (num < 0) ? 65536 - lp : lp;
    end
  end

  function automatic longint unsigned sig_lookup(longint z);
    longint          q, diff, frac;
    int              k;
    if (z < -HALF) return 0;
    if (z >= HALF) return 65536;
    q = (z + HALF) * NSAMP;
    k = int'(q >> 20);
    if (k >= NSAMP) k = NSAMP - 1;
    frac = longint'(q & 64'hFFFFF);
    diff = longint'(sig_tab[k + 1]) - longint'(sig_tab[k]);
    return longint'(sig_tab[k]) + ((diff * frac) >>> 20);
  endfunction

  task automatic axis_eval(input logic [31:0] pos, input longint org,
                           input longint unsigned inv, input int nreg,
                           output logic [18:0] soft_v, output logic [23:0] grad);
    longint          s, d, z;
    longint unsigned l, ssum, gsum, g;
    int              n;
    s    = ((longint'($signed(pos)) - org) * longint'(inv)) >>> 16;
    n    = (nreg > sfg_pkg::MAX_REGIONS) ? sfg_pkg::MAX_REGIONS : nreg;
    ssum = 0;
    gsum = 0;
    for (int i = 1; i < n; i++) begin
      d    = s - longint'(i) * 65536;
      z    = (longint'(steep) * d) >>> 8;
      l    = sig_lookup(z);
      ssum += l;
      gsum += steep * ((l * (65536 - l)) >> 16);
    end
    g      = (gsum * inv) >> 24;
    soft_v = (ssum > sfg_pkg::SOFT_MAX) ? sfg_pkg::SOFT_MAX : ssum[18:0];
    grad   = (g > sfg_pkg::GRAD_MAX) ? sfg_pkg::GRAD_MAX : g[23:0];
  endtask

  always @(negedge clk_i or negedge rst_ni) begin
    sfg_pkg::sfg_out_t exp_r;
    if (!rst_ni) begin
      org_x  = 0;
      org_y  = 0;
      inv_w  = 4096;
      inv_h  = 4096;
      nreg_x = 1;
      nreg_y = 1;
      steep  = 2560;
      errors = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sfg_pkg::CFG_ORIGIN_X:  org_x  = longint'($signed(cfg_wdata_i));
          sfg_pkg::CFG_ORIGIN_Y:  org_y  = longint'($signed(cfg_wdata_i));
          sfg_pkg::CFG_INV_W:     inv_w  = cfg_wdata_i[15:0];
          sfg_pkg::CFG_INV_H:     inv_h  = cfg_wdata_i[15:0];
          sfg_pkg::CFG_REGIONS_X: nreg_x = cfg_wdata_i[3:0];
          sfg_pkg::CFG_REGIONS_Y: nreg_y = cfg_wdata_i[3:0];
          sfg_pkg::CFG_STEEPNESS: steep  = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (done_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", result_i);
        end else begin
          exp_r = expected_q.pop_front();
          if (result_i !== exp_r) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp soft %h/%h grad %h/%h last %b, got %h/%h %h/%h %b",
                       exp_r.soft_x, exp_r.soft_y, exp_r.grad_x, exp_r.grad_y,
                       exp_r.last_out, result_i.soft_x, result_i.soft_y,
                       result_i.grad_x, result_i.grad_y, result_i.last_out);
          end
        end
      end
      if (start_i && !busy_i) begin
        axis_eval(in_i.pos_x, org_x, inv_w, nreg_x, exp_r.soft_x, exp_r.grad_x);
        axis_eval(in_i.pos_y, org_y, inv_h, nreg_y, exp_r.soft_y, exp_r.grad_y);
        exp_r.last_out = in_i.last_pin;
        expected_q.push_back(exp_r);
      end
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for soft_floor_with_gradient_core; checking lives in
// sfg_checker; depends on sfg_pkg, the core and the checker
module tb;

  localparam logic [2:0] CFG_SPARE_IDX = 3'd7;  // beyond the register list, ignored
  localparam int         PIPE_LAT      = 9;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  sfg_pkg::sfg_in_t  pin = '0;
  logic              done;
  sfg_pkg::sfg_out_t result;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_idx = '0;
  logic [31:0]       cfg_data = '0;
  int                pending, errors;

  // local copy of the setting, only to aim pins at the region boundaries
  logic [31:0]       cur_org_x, cur_org_y;
  int                cur_inv_w, cur_inv_h, cur_reg_x, cur_reg_y;
  int                burst_left;
  bit                no_gaps;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  soft_floor_with_gradient_core uut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .in_i(pin),
    .done_o(done), .result_o(result), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_data)
  );

  sfg_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .in_i(pin),
    .done_i(done), .result_i(result), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_data), .pending_o(pending), .errors_o(errors)
  );

  // one transaction: held until an edge with busy low, sampled mid-cycle
  task automatic send_pin(input logic [31:0] px, input logic [31:0] py, input logic lp);
    bit b;
    start <= 1'b1;
    pin   <= '{pos_x: px, pos_y: py, last_pin: lp};
    do begin
      @(negedge clk) b = busy;
      @(posedge clk);
    end while (b);
  endtask

  // bursty sender: random burst lengths with random gaps, or none at all
  task automatic send_paced(input logic [31:0] px, input logic [31:0] py, input logic lp);
    send_pin(px, py, lp);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // drain the pipeline, then rewrite every register
  task automatic apply_setting(input logic [31:0] ox, input logic [31:0] oy,
                               input int iw, input int ih, input int rx, input int ry,
                               input int st);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
    cfg_write(sfg_pkg::CFG_ORIGIN_X, ox);
    cfg_write(sfg_pkg::CFG_ORIGIN_Y, oy);
    cfg_write(sfg_pkg::CFG_INV_W, iw);
    cfg_write(sfg_pkg::CFG_INV_H, ih);
    cfg_write(sfg_pkg::CFG_REGIONS_X, rx);
    cfg_write(sfg_pkg::CFG_REGIONS_Y, ry);
    cfg_write(sfg_pkg::CFG_STEEPNESS, st);
    cfg_write(CFG_SPARE_IDX, $urandom);
    cfg_we <= 1'b0;
    cur_org_x = ox;  cur_org_y = oy;
    cur_inv_w = iw;  cur_inv_h = ih;
    cur_reg_x = rx;  cur_reg_y = ry;
  endtask

  // mostly positions aimed a little beyond the region span, some fully random
  function automatic logic [31:0] pick_coord(input logic [31:0] org, input int inv,
                                             input int nreg);
    longint tgt, off, val;
    if ($urandom_range(0, 4) == 0 || inv == 0) return $urandom;
    tgt = longint'($urandom_range(0, (nreg + 3) * 65536)) - 2 * 65536;
    off = (tgt * 65536) / inv;
    val = longint'($signed(org)) + off;
    if (val > 64'sd2147483647) val = 64'sd2147483647;
    if (val < -64'sd2147483648) val = -64'sd2147483648;
    return val[31:0];
  endfunction

  function automatic int pick_inv();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return 65535;
      2:       return 0;
      default: return $urandom_range(256, 32768);
    endcase
  endfunction

  function automatic int pick_steep();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return 65535;
      2:       return 0;
      3:       return $urandom_range(1, 65535);
      default: return $urandom_range(256, 4096);
    endcase
  endfunction

  function automatic int pick_regions();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 8);
  endfunction

  logic [31:0] corner [7] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                              32'h1, 32'h0001_0000, 32'h0001_8000};

  initial begin
    cur_org_x = '0;  cur_org_y = '0;
    cur_inv_w = 4096;  cur_inv_h = 4096;
    cur_reg_x = 1;  cur_reg_y = 1;
    burst_left = 0;
    no_gaps = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: one region each, so everything comes out zero
    send_pin(corner[1], corner[2], 1'b1);
    send_pin(corner[2], corner[1], 1'b0);
    // eight regions, fine reciprocal; corners and exact boundaries
    apply_setting(32'h0, 32'h0, 65535, 65535, 8, 8, 2560);
    for (int i = 0; i < 7; i++) send_pin(corner[i], corner[6 - i], i[0]);
    for (int i = 0; i <= 8; i++) send_pin(i << 16, (i << 16) + 32'h8000, 1'b0);
    // extreme origins, regions beyond the maximum, maximum steepness
    apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 1, 65535, 15, 0, 65535);
    for (int i = 0; i < 4; i++) send_pin(corner[i], corner[i], 1'b1);
    // zero reciprocal and zero steepness
    apply_setting(32'h0, 32'h0, 0, 4096, 8, 8, 0);
    send_pin(corner[2], corner[5], 1'b0);
    send_pin(corner[6], corner[1], 1'b1);

    // random phases; the last uses extreme settings again
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 8)
        apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 65535, 1, 8, 8, 1);
      else
        apply_setting($urandom, ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 65536),
                      pick_inv(), pick_inv(), pick_regions(), pick_regions(),
                      pick_steep());
      no_gaps = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < 210; n++)
        send_paced(pick_coord(cur_org_x, cur_inv_w, cur_reg_x),
                   pick_coord(cur_org_y, cur_inv_h, cur_reg_y), $urandom_range(0, 1));
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
